### rtl/jddm_pkg.sv
// Shared types, codes and constant tables of the joystick differential drive mixer.
// Depends on nothing; the mixer top level imports it.
package jddm_pkg;

    localparam int COORD_W = 13;
    localparam int CFG_W   = 12;
    localparam int GEAR_W  = 4;
    localparam int DUTY_W  = 13;
    localparam int REGION_W = 4;
    localparam int MAG_W   = 14;   // |raw duty| reaches 8192
    localparam int RECIP_W = 23;   // gear * ceil(2^22 / 10)
    localparam int RECIP_SHIFT = 22;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [CFG_W-1:0]          cfg_data_t;
    typedef logic [1:0]                cfg_index_t;
    typedef logic [GEAR_W-1:0]         gear_t;
    typedef logic [DUTY_W-1:0]         duty_t;
    typedef logic [REGION_W-1:0]       region_t;

    // Register indexes
    localparam cfg_index_t CFG_NARROW_DEAD_ZONE = 2'd0;
    localparam cfg_index_t CFG_WIDE_DEAD_ZONE   = 2'd1;
    localparam cfg_index_t CFG_FULL_SCALE       = 2'd2;

    localparam cfg_data_t NARROW_DEAD_ZONE_RST = 12'd10;
    localparam cfg_data_t WIDE_DEAD_ZONE_RST   = 12'd20;
    localparam cfg_data_t FULL_SCALE_RST       = 12'd4095;

    // Region codes
    localparam region_t REGION_STOP       = 4'd0;
    localparam region_t REGION_FORWARD    = 4'd1;
    localparam region_t REGION_BACK       = 4'd2;
    localparam region_t REGION_SPOT_LEFT  = 4'd3;
    localparam region_t REGION_SPOT_RIGHT = 4'd4;
    localparam region_t REGION_OCT1       = 4'd5;
    localparam region_t REGION_OCT8       = 4'd12;

    localparam duty_t DUTY_MAX = 13'd8191;

    // Per-region mix: direction bits and 0/1 weights of full scale, |x|, |y| per side
    typedef struct packed {
        logic left_on;
        logic right_on;
        logic o_left;
        logic a_left;
        logic b_left;
        logic o_right;
        logic a_right;
        logic b_right;
    } weights_t;

    localparam weights_t W_STOP       = 8'b0000_0000;
    localparam weights_t W_FORWARD    = 8'b1100_1001;
    localparam weights_t W_BACK       = 8'b0000_1001;
    localparam weights_t W_SPOT_LEFT  = 8'b0101_0010;
    localparam weights_t W_SPOT_RIGHT = 8'b1001_0010;

    // Indexed by {octant, over full scale}
    localparam weights_t OCT_W [16] = '{
        8'b1010_1010, 8'b1001_0101,
        8'b1111_0001, 8'b1100_1110,
        8'b1100_1110, 8'b1111_0001,
        8'b0101_0101, 8'b0110_1010,
        8'b0110_1010, 8'b0101_0101,
        8'b0011_0001, 8'b0000_1110,
        8'b0000_1110, 8'b0011_0001,
        8'b1001_0101, 8'b1010_1010
    };

    // gear * 419431; (p * this) >> 22 equals floor(p * gear / 10) for p * gear < 2^18
    localparam logic [RECIP_W-1:0] GEAR_RECIP [16] = '{
        23'd0,       23'd419431,  23'd838862,  23'd1258293,
        23'd1677724, 23'd2097155, 23'd2516586, 23'd2936017,
        23'd3355448, 23'd3774879, 23'd4194310, 23'd4613741,
        23'd5033172, 23'd5452603, 23'd5872034, 23'd6291465
    };

endpackage

### rtl/joystick_differential_drive_mixer.sv
// Joystick differential drive mixer: region sort, duty mix and gear scaling.
// Depends on jddm_pkg for field types, region codes and the weight tables.
//
// Channel   Signals                                        Handshake
// --------  ---------------------------------------------  -----------------------------
// sample    start, busy, stick_x, stick_y, gear_level      taken when start && !busy
// result    done, left_on, right_on, left_duty,            one-cycle strobe on done
//           right_duty, motion_region
// config    cfg_valid, cfg_ready, cfg_index, cfg_data      write when cfg_valid && cfg_ready
//
// One sample per cycle, sustained; the result strobe follows the accepting edge through the
// input register, then one pass of compares and a 14x23 reciprocal multiply per side into
// the result register. busy never rises: there is no loop or shared unit to wait on.
// rst_n clears the valid flags and loads the register reset values at once.
// The receiver cannot stall, so nothing back-pressures the pipe.
module joystick_differential_drive_mixer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  jddm_pkg::coord_t     stick_x,
    input  jddm_pkg::coord_t     stick_y,
    input  jddm_pkg::gear_t      gear_level,
    output logic                 done,
    output logic                 left_on,
    output logic                 right_on,
    output jddm_pkg::duty_t      left_duty,
    output jddm_pkg::duty_t      right_duty,
    output jddm_pkg::region_t    motion_region,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  jddm_pkg::cfg_index_t cfg_index,
    input  jddm_pkg::cfg_data_t  cfg_data
);
    import jddm_pkg::*;

    localparam int PROD_W = MAG_W + RECIP_W;

    // Configuration registers
    cfg_data_t narrow_dz_reg;
    cfg_data_t wide_dz_reg;
    cfg_data_t full_scale_reg;

    // Input stage
    logic      in_valid_reg;
    coord_t    x_reg;
    coord_t    y_reg;
    gear_t     gear_reg;

    // Result stage
    logic      done_reg;
    logic      left_on_reg;
    logic      right_on_reg;
    duty_t     left_duty_reg;
    duty_t     right_duty_reg;
    region_t   region_reg;

    // Mix logic
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic               x_neg;
    logic               x_pos;
    logic               y_neg;
    logic               y_pos;
    logic               over;
    logic [2:0]         oct;
    logic               oct_hit;
    region_t            region_next;
    weights_t           w;
    logic [MAG_W-1:0]   mag_left;
    logic [MAG_W-1:0]   mag_right;
    duty_t              left_duty_next;
    duty_t              right_duty_next;

    // |full*o - |x|*a - |y|*b|
    function automatic logic [MAG_W-1:0] raw_mag(
        input logic o, input logic a, input logic b,
        input cfg_data_t fs, input logic [COORD_W-1:0] mx, input logic [COORD_W-1:0] my
    );
        logic [MAG_W:0] term_f;
        logic [MAG_W:0] term_a;
        logic [MAG_W:0] term_b;
        logic [MAG_W:0] v;
        logic [MAG_W:0] m;
        term_f = o ? {3'b000, fs} : '0;
        term_a = a ? {2'b00, mx} : '0;
        term_b = b ? {2'b00, my} : '0;
        v = term_f - term_a - term_b;
        m = v[MAG_W] ? (~v + 1'b1) : v;
        return m[MAG_W-1:0];
    endfunction

    // floor(m * gear / 10), saturated to the duty range
    function automatic duty_t scale_duty(input logic [MAG_W-1:0] m, input gear_t g);
        logic [PROD_W-1:0]  prod;
        logic [PROD_W-RECIP_SHIFT-1:0] q;
        prod = PROD_W'(m) * PROD_W'(GEAR_RECIP[g]);
        q = prod[PROD_W-1:RECIP_SHIFT];
        return (q > (PROD_W-RECIP_SHIFT)'(DUTY_MAX)) ? DUTY_MAX : q[DUTY_W-1:0];
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration writes; drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_dz_reg  <= NARROW_DEAD_ZONE_RST;
            wide_dz_reg    <= WIDE_DEAD_ZONE_RST;
            full_scale_reg <= FULL_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NARROW_DEAD_ZONE: narrow_dz_reg  <= cfg_data;
                CFG_WIDE_DEAD_ZONE:   wide_dz_reg    <= cfg_data;
                CFG_FULL_SCALE:       full_scale_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Capture each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            x_reg    <= stick_x;
            y_reg    <= stick_y;
            gear_reg <= gear_level;
        end
    end

    // Sort the sample into the first matching region, in priority order
    always_comb
    begin
        x_neg = x_reg[COORD_W-1];
        y_neg = y_reg[COORD_W-1];
        x_pos = !x_neg && (x_reg != '0);
        y_pos = !y_neg && (y_reg != '0);
        ax = x_neg ? (~x_reg + 1'b1) : x_reg;
        ay = y_neg ? (~y_reg + 1'b1) : y_reg;
        over = ({1'b0, ax} + {1'b0, ay}) > {2'b00, full_scale_reg};

        oct         = 3'd0;
        oct_hit     = 1'b0;
        region_next = REGION_STOP;
        w           = W_STOP;

        if (ax < {1'b0, wide_dz_reg} && ay < {1'b0, wide_dz_reg})
        begin
            region_next = REGION_STOP;
        end
        else if (ax < {1'b0, narrow_dz_reg} && y_neg)
        begin
            region_next = REGION_FORWARD;
            w = W_FORWARD;
        end
        else if (ax < {1'b0, narrow_dz_reg} && y_pos)
        begin
            region_next = REGION_BACK;
            w = W_BACK;
        end
        else if (x_neg && ay <= {1'b0, wide_dz_reg})
        begin
            region_next = REGION_SPOT_LEFT;
            w = W_SPOT_LEFT;
        end
        else if (x_pos && ay <= {1'b0, wide_dz_reg})
        begin
            region_next = REGION_SPOT_RIGHT;
            w = W_SPOT_RIGHT;
        end
        else if (x_pos && y_neg)
        begin
            oct_hit = 1'b1;
            oct = (ax >= ay) ? 3'd0 : 3'd1;
        end
        else if (x_neg && y_neg)
        begin
            oct_hit = 1'b1;
            oct = (ay > ax) ? 3'd2 : 3'd3;
        end
        else if (x_neg && y_pos)
        begin
            oct_hit = 1'b1;
            oct = (ax > ay) ? 3'd4 : 3'd5;
        end
        else if (x_pos && y_pos)
        begin
            oct_hit = 1'b1;
            oct = (ay >= ax) ? 3'd6 : 3'd7;
        end

        if (oct_hit)
        begin
            region_next = REGION_OCT1 + {1'b0, oct};
            w = OCT_W[{oct, over}];
        end

        mag_left  = raw_mag(w.o_left, w.a_left, w.b_left, full_scale_reg, ax, ay);
        mag_right = raw_mag(w.o_right, w.a_right, w.b_right, full_scale_reg, ax, ay);
        left_duty_next  = scale_duty(mag_left, gear_reg);
        right_duty_next = scale_duty(mag_right, gear_reg);
    end

    // Result register: strobe one cycle per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            left_on_reg    <= w.left_on;
            right_on_reg   <= w.right_on;
            left_duty_reg  <= left_duty_next;
            right_duty_reg <= right_duty_next;
            region_reg     <= region_next;
        end
    end

    assign done          = done_reg;
    assign left_on       = left_on_reg;
    assign right_on      = right_on_reg;
    assign left_duty     = left_duty_reg;
    assign right_duty    = right_duty_reg;
    assign motion_region = region_reg;

    // Every accepted sample comes out as a result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
    else $error("accepted sample produced no result");

    // Stop gives both sides off and idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && motion_region == REGION_STOP) |->
            (!left_on && !right_on && left_duty == '0 && right_duty == '0))
    else $error("stop region with nonzero output");

    // Straight runs drive both sides equally
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (motion_region == REGION_FORWARD || motion_region == REGION_BACK)) |->
            (left_duty == right_duty && left_on == right_on))
    else $error("straight run with unequal sides");

    // Region code stays within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (motion_region <= REGION_OCT8))
    else $error("region code out of range");

endmodule

### sim/drive_mix_checker.sv
// Result checker of the joystick differential drive mixer: tracks register writes,
// predicts directions, duties and region for every taken sample, compares the strobes.
// Depends on jddm_pkg for the port types and the region and register codes.
`timescale 1ns / 1ps

module drive_mix_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  jddm_pkg::coord_t     stick_x,
    input  jddm_pkg::coord_t     stick_y,
    input  jddm_pkg::gear_t      gear_level,
    input  logic                 done,
    input  logic                 left_on,
    input  logic                 right_on,
    input  jddm_pkg::duty_t      left_duty,
    input  jddm_pkg::duty_t      right_duty,
    input  jddm_pkg::region_t    motion_region,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  jddm_pkg::cfg_index_t cfg_index,
    input  jddm_pkg::cfg_data_t  cfg_data,
    output int                   error_count,
    output int                   pending
);
    import jddm_pkg::*;

    localparam int DUTY_CEIL = 8191;

    // Mix word: left_on, right_on, then (full, |x|, |y|) weights for left and right
    localparam logic [7:0] MIX_STOP       = 8'b0000_0000;
    localparam logic [7:0] MIX_FORWARD    = 8'b1100_1001;
    localparam logic [7:0] MIX_BACK       = 8'b0000_1001;
    localparam logic [7:0] MIX_SPOT_LEFT  = 8'b0101_0010;
    localparam logic [7:0] MIX_SPOT_RIGHT = 8'b1001_0010;

    // Two entries per octant: within full scale, then beyond it
    localparam logic [7:0] OCTANT_MIX [16] = '{
        8'b1010_1010, 8'b1001_0101,
        8'b1111_0001, 8'b1100_1110,
        8'b1100_1110, 8'b1111_0001,
        8'b0101_0101, 8'b0110_1010,
        8'b0110_1010, 8'b0101_0101,
        8'b0011_0001, 8'b0000_1110,
        8'b0000_1110, 8'b0011_0001,
        8'b1001_0101, 8'b1010_1010
    };

    typedef struct {
        int      x;
        int      y;
        int      gear;
        logic    left_on;
        logic    right_on;
        duty_t   left_duty;
        duty_t   right_duty;
        region_t region;
    } drive_expect_t;

    drive_expect_t drive_expect_q[$];

    int nz_q;
    int wz_q;
    int fs_q;

    function automatic duty_t side_duty(int ax, int ay, logic [2:0] oab, int gear);
        int v;
        int m;
        int d;
        v = (oab[2] ? fs_q : 0) - (oab[1] ? ax : 0) - (oab[0] ? ay : 0);
        m = (v < 0) ? -v : v;
        d = (m * gear) / 10;
        return (d > DUTY_CEIL) ? duty_t'(DUTY_CEIL) : duty_t'(d);
    endfunction

    function automatic drive_expect_t predict_drive(coord_t x, coord_t y, gear_t gear);
        drive_expect_t e;
        int          xi;
        int          yi;
        int          ax;
        int          ay;
        int          oct;
        bit          over;
        logic [7:0]  w;
        xi = x;
        yi = y;
        ax = (xi < 0) ? -xi : xi;
        ay = (yi < 0) ? -yi : yi;
        over = (ax + ay) > fs_q;
        oct = -1;
        e.x = xi;
        e.y = yi;
        e.gear = gear;
        e.region = REGION_STOP;
        // first match wins; no match at all falls back to stop
        if (ax < wz_q && ay < wz_q)
            e.region = REGION_STOP;
        else if (ax < nz_q && yi < 0)
            e.region = REGION_FORWARD;
        else if (ax < nz_q && yi > 0)
            e.region = REGION_BACK;
        else if (xi < 0 && ay <= wz_q)
            e.region = REGION_SPOT_LEFT;
        else if (xi > 0 && ay <= wz_q)
            e.region = REGION_SPOT_RIGHT;
        else if (xi > 0 && yi < 0)
            oct = (ax >= ay) ? 0 : 1;
        else if (xi < 0 && yi < 0)
            oct = (ay > ax) ? 2 : 3;
        else if (xi < 0 && yi > 0)
            oct = (ax > ay) ? 4 : 5;
        else if (xi > 0 && yi > 0)
            oct = (ay >= ax) ? 6 : 7;

        if (oct >= 0)
        begin
            e.region = REGION_OCT1 + region_t'(oct);
            w = OCTANT_MIX[2 * oct + (over ? 1 : 0)];
        end
        else
        begin
            case (e.region)
                REGION_FORWARD:    w = MIX_FORWARD;
                REGION_BACK:       w = MIX_BACK;
                REGION_SPOT_LEFT:  w = MIX_SPOT_LEFT;
                REGION_SPOT_RIGHT: w = MIX_SPOT_RIGHT;
                default:           w = MIX_STOP;
            endcase
        end
        e.left_on = w[7];
        e.right_on = w[6];
        e.left_duty = side_duty(ax, ay, w[5:3], gear);
        e.right_duty = side_duty(ax, ay, w[2:0], gear);
        return e;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns drive_mix_checker: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_q <= 10;
            wz_q <= 20;
            fs_q <= 4095;
            drive_expect_q.delete();
            pending <= 0;
        end
        else
        begin
            drive_expect_t want;
            string         tag;
            if (done)
            begin
                if (drive_expect_q.size() == 0)
                    report_mismatch("result strobe with no sample outstanding");
                else
                begin
                    want = drive_expect_q.pop_front();
                    tag = $sformatf("x=%0d y=%0d gear=%0d", want.x, want.y, want.gear);
                    if (left_on !== want.left_on)
                        report_mismatch($sformatf("%s left_on %b, predicted %b",
                                                  tag, left_on, want.left_on));
                    if (right_on !== want.right_on)
                        report_mismatch($sformatf("%s right_on %b, predicted %b",
                                                  tag, right_on, want.right_on));
                    if (left_duty !== want.left_duty)
                        report_mismatch($sformatf("%s left_duty %0d, predicted %0d",
                                                  tag, left_duty, want.left_duty));
                    if (right_duty !== want.right_duty)
                        report_mismatch($sformatf("%s right_duty %0d, predicted %0d",
                                                  tag, right_duty, want.right_duty));
                    if (motion_region !== want.region)
                        report_mismatch($sformatf("%s motion_region %0d, predicted %0d",
                                                  tag, motion_region, want.region));
                end
            end
            if (start && !busy)
                drive_expect_q.push_back(predict_drive(stick_x, stick_y, gear_level));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NARROW_DEAD_ZONE: nz_q <= cfg_data;
                    CFG_WIDE_DEAD_ZONE:   wz_q <= cfg_data;
                    CFG_FULL_SCALE:       fs_q <= cfg_data;
                    default:              ;
                endcase
            end
            pending <= drive_expect_q.size();
        end
    end

endmodule

### sim/tb_top.sv
// Top of the joystick differential drive mixer testbench: clock, reset, sample and
// register stimulus, verdict. Depends on jddm_pkg, the mixer RTL and drive_mix_checker.
`timescale 1ns / 1ps

module tb_top;
    import jddm_pkg::*;

    // The index field has one code with no register behind it; writes there must be dropped
    localparam cfg_index_t CFG_SPARE_INDEX = 2'd3;
    localparam int GAP_MAX = 19;
    localparam int COORD_MIN = -4096;
    localparam int COORD_MAX = 4095;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    coord_t     stick_x = '0;
    coord_t     stick_y = '0;
    gear_t      gear_level = '0;
    logic       cfg_valid = 1'b0;
    cfg_index_t cfg_index = CFG_NARROW_DEAD_ZONE;
    cfg_data_t  cfg_data = '0;

    logic       busy;
    logic       done;
    logic       left_on;
    logic       right_on;
    duty_t      left_duty;
    duty_t      right_duty;
    region_t    motion_region;
    logic       cfg_ready;

    int         mix_errors;
    int         mix_pending;

    // Shadow of the register values, used only to aim random samples at the thresholds
    int         cur_nz = 10;
    int         cur_wz = 20;
    int         cur_fs = 4095;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    joystick_differential_drive_mixer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .stick_x       (stick_x),
        .stick_y       (stick_y),
        .gear_level    (gear_level),
        .done          (done),
        .left_on       (left_on),
        .right_on      (right_on),
        .left_duty     (left_duty),
        .right_duty    (right_duty),
        .motion_region (motion_region),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    drive_mix_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .stick_x       (stick_x),
        .stick_y       (stick_y),
        .gear_level    (gear_level),
        .done          (done),
        .left_on       (left_on),
        .right_on      (right_on),
        .left_duty     (left_duty),
        .right_duty    (right_duty),
        .motion_region (motion_region),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (mix_errors),
        .pending       (mix_pending)
    );

    function automatic int clamp_coord(int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int full_range_coord();
        int r;
        r = $urandom_range(0, 8191);
        return r - 4096;
    endfunction

    function automatic int jitter(int n);
        int r;
        r = $urandom_range(0, 2 * n);
        return r - n;
    endfunction

    function automatic int rsign();
        return ($urandom_range(0, 1) == 1) ? 1 : -1;
    endfunction

    // Offer one sample and hold it until the block takes it. Call right after a rising
    // edge; start is left high so back-to-back samples never drop it between transactions.
    task automatic send_sample(int x, int y, int g);
        start <= 1'b1;
        stick_x <= coord_t'(x);
        stick_y <= coord_t'(y);
        gear_level <= gear_t'(g);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start for a while; the fields keep their last values
    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop offering samples and hold until every outstanding result has come back.
    // Advance to a rising edge first so that the checker's count includes the last transaction.
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (mix_pending != 0);
    endtask

    // One register transaction; cfg_valid stays high so consecutive writes run back to back
    task automatic write_register(cfg_index_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= cfg_data_t'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Registers change only with the block idle: drain first, then write all three
    // plus one write to the spare index, which must leave everything as it was.
    task automatic set_dead_zones(int nz, int wz, int fs);
        wait_for_results();
        write_register(CFG_NARROW_DEAD_ZONE, nz);
        write_register(CFG_WIDE_DEAD_ZONE, wz);
        write_register(CFG_FULL_SCALE, fs);
        write_register(CFG_SPARE_INDEX, $urandom_range(0, 4095));
        cfg_valid <= 1'b0;
        cur_nz = nz;
        cur_wz = wz;
        cur_fs = fs;
    endtask

    // Random sample aimed at the decision boundaries: the dead zones, the diagonals,
    // the full-scale split line, the axes and the field extremes, with plain uniform values mixed in.
    task automatic send_random_sample();
        int mode;
        int x;
        int y;
        int g;
        int a;
        int zones[3];
        int extremes[5];
        zones = '{0, cur_nz, cur_wz};
        extremes = '{0, COORD_MIN, COORD_MAX, 1, -1};
        mode = $urandom_range(0, 9);
        case (mode)
            3:
            begin
                x = clamp_coord(rsign() * zones[$urandom_range(0, 2)] + jitter(3));
                y = clamp_coord(rsign() * zones[$urandom_range(0, 2)] + jitter(3));
            end
            4, 5:
            begin
                x = full_range_coord();
                y = clamp_coord(rsign() * x + jitter(2));
            end
            6, 7:
            begin
                a = $urandom_range(0, cur_fs);
                x = clamp_coord(rsign() * a + jitter(2));
                y = clamp_coord(rsign() * (cur_fs - a) + jitter(2));
            end
            8:
            begin
                x = full_range_coord();
                y = clamp_coord(rsign() * (($urandom_range(0, 1) == 1) ? cur_wz : 0)
                                + jitter(2));
            end
            9:
            begin
                x = extremes[$urandom_range(0, 4)];
                y = ($urandom_range(0, 1) == 1) ? extremes[$urandom_range(0, 4)]
                                                : full_range_coord();
                if ($urandom_range(0, 1) == 1)
                begin
                    a = x;
                    x = y;
                    y = a;
                end
            end
            default:
            begin
                x = full_range_coord();
                y = full_range_coord();
            end
        endcase
        // mostly legal gears, now and then one above ten
        g = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10);
        send_sample(x, y, g);
    endtask

    // Random samples with bursts of idle cycles; the burst rate is re-drawn every 50
    // samples, and a rate of zero gives stretches of back-to-back transactions.
    task automatic run_random(int count, bit allow_gaps);
        int rate;
        rate = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                rate = allow_gaps ? $urandom_range(0, 3) : 0;
            if (rate != 0 && $urandom_range(0, 4 * rate) == 0)
                idle_cycles($urandom_range(1, GAP_MAX));
            send_random_sample();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples with the reset register values: each fixed region,
        // every octant on both sides of the full-scale split, ties on the diagonals,
        // the field extremes, gear zero and gears above ten (duty saturation).
        send_sample(0, 0, 10);
        send_sample(5, -100, 10);
        send_sample(-5, 100, 10);
        send_sample(-100, 0, 10);
        send_sample(100, 20, 10);
        send_sample(3000, -1000, 10);
        send_sample(3000, -3000, 10);
        send_sample(1000, -3000, 7);
        send_sample(2000, -3000, 10);
        send_sample(-1000, -3000, 10);
        send_sample(-2000, -3000, 10);
        send_sample(-3000, -1000, 5);
        send_sample(-3000, -3000, 10);
        send_sample(-3000, 1000, 10);
        send_sample(-3000, 2000, 10);
        send_sample(-1000, 3000, 10);
        send_sample(-3000, 3000, 3);
        send_sample(1000, 3000, 10);
        send_sample(3000, 3000, 10);
        send_sample(3000, 1000, 10);
        send_sample(3000, 2000, 10);
        send_sample(-4096, -4096, 15);
        send_sample(4095, 4095, 10);
        send_sample(-4096, 0, 10);
        send_sample(0, -4096, 10);
        send_sample(4095, -4095, 0);
        send_sample(-4096, 4095, 15);
        run_random(150, 1'b1);

        // Zero dead zones: x on the axis matches no region and must come out as stop
        set_dead_zones(0, 0, 1);
        send_sample(0, 100, 10);
        send_sample(0, -100, 10);
        send_sample(0, 0, 5);
        run_random(150, 1'b1);

        set_dead_zones(4095, 4095, 4095);
        run_random(120, 1'b1);

        // Full scale of zero is taken as it is
        set_dead_zones(0, 0, 0);
        run_random(120, 1'b1);

        repeat (4)
        begin
            set_dead_zones($urandom_range(0, 300), $urandom_range(0, 400),
                           $urandom_range(1, 4095));
            run_random(150, 1'b1);
        end

        // Last part: back to the reset values, no idling at all
        set_dead_zones(10, 20, 4095);
        run_random(160, 1'b0);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mix_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

### joystick_differential_drive_mixer.f
rtl/jddm_pkg.sv
rtl/joystick_differential_drive_mixer.sv
sim/drive_mix_checker.sv
sim/tb_top.sv
